// ----- rtl/fpcalc_pkg.sv -----
// Shared types, codes and constants of the calculator keypad engine.
package fpcalc_pkg;

    localparam int unsigned ValW = 64;
    localparam logic [ValW-1:0] Scale = 64'd10000;
    localparam logic [ValW-1:0] ScaleSq = 64'd100000000;
    localparam logic [ValW-1:0] Hundred = 64'd100;
    localparam logic [ValW-1:0] DelDiv = 64'd100000;
    localparam logic [16:0] FracTen = 17'd10;
    localparam logic [16:0] FracLimit = 17'd10000;

    typedef enum logic [4:0] {
        KEY_DIGIT = 5'd0, KEY_DZERO = 5'd1, KEY_POINT = 5'd2, KEY_CLEAR = 5'd3,
        KEY_DELETE = 5'd4, KEY_NEGATE = 5'd5, KEY_ADD = 5'd6, KEY_SUB = 5'd7,
        KEY_MUL = 5'd8, KEY_DIV = 5'd9, KEY_EQUALS = 5'd10, KEY_PERCENT = 5'd11,
        KEY_SQUARE = 5'd12, KEY_SQRT = 5'd13, KEY_RECIP = 5'd14, KEY_MC = 5'd15,
        KEY_MR = 5'd16, KEY_MADD = 5'd17, KEY_MSUB = 5'd18
    } key_t;

    typedef enum logic [2:0] {
        PEND_NONE = 3'd0, PEND_ADD = 3'd1, PEND_SUB = 3'd2,
        PEND_MUL = 3'd3, PEND_DIV = 3'd4
    } pend_t;

    // operation requested of the shared arithmetic unit
    typedef enum logic [1:0] {
        AU_MUL = 2'd0, AU_DIV = 2'd1, AU_SQRT = 2'd2
    } au_op_t;

    typedef struct packed {
        logic            start;
        au_op_t          op;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } au_req_t;

    typedef struct packed {
        logic            done;
        logic [ValW-1:0] result;
    } au_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_OP1, ST_WAIT1, ST_OP2, ST_WAIT2, ST_OUT
    } state_t;

endpackage

// ----- rtl/fpcalc_arith.sv -----
// Shared iterative unit: shift-add multiply, signed restoring divide, floor square root.
module fpcalc_arith (
    input  logic                aclk,
    input  logic                aresetn,
    input  fpcalc_pkg::au_req_t req,
    output fpcalc_pkg::au_rsp_t rsp
);
    localparam int unsigned W = fpcalc_pkg::ValW;

    logic                busy_reg, busy_next;
    fpcalc_pkg::au_op_t  op_reg, op_next;
    logic [W-1:0]        acc_reg, acc_next;   // product / quotient / root
    logic [W-1:0]        rem_reg, rem_next;   // remainder
    logic [W-1:0]        x_reg, x_next;       // multiplicand / dividend magnitude
    logic [W-1:0]        y_reg, y_next;       // multiplier / divisor magnitude / bit
    logic                neg_reg, neg_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;

    logic [W:0]   trial;
    logic [W-1:0] rsh;
    logic [W-1:0] sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = '0;
        rsh       = '0;
        sum       = acc_reg + y_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            rem_next  = '0;
            acc_next  = '0;
            case (req.op)
                fpcalc_pkg::AU_MUL: begin
                    x_next   = req.a;
                    y_next   = req.b;
                    neg_next = 1'b0;
                end
                fpcalc_pkg::AU_DIV: begin
                    x_next   = req.a[W-1] ? -req.a : req.a;
                    y_next   = req.b[W-1] ? -req.b : req.b;
                    neg_next = req.a[W-1] ^ req.b[W-1];
                end
                fpcalc_pkg::AU_SQRT: begin
                    // non-positive input gives zero root
                    rem_next = ($signed(req.a) <= 0) ? '0 : req.a;
                    x_next   = '0;
                    y_next   = {2'b01, {(W-2){1'b0}}};
                    neg_next = 1'b0;
                end
                default: begin
                    x_next   = req.a;
                    y_next   = req.b;
                    neg_next = 1'b0;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                fpcalc_pkg::AU_MUL: begin
                    if (y_reg[0]) acc_next = acc_reg + x_reg;
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'(W - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                fpcalc_pkg::AU_DIV: begin
                    rsh   = {rem_reg[W-2:0], x_reg[W-1]};
                    trial = {1'b0, rsh} - {1'b0, y_reg};
                    x_next = x_reg << 1;
                    if (!trial[W] || rem_reg[W-1]) begin
                        rem_next = trial[W-1:0];
                        acc_next = {acc_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = rsh;
                        acc_next = {acc_reg[W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'(W - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        if (neg_reg) acc_next = -acc_next;
                    end
                end
                default: begin
                    // digit-by-digit root: acc = root, y = bit
                    if (rem_reg >= sum) begin
                        rem_next = rem_reg - sum;
                        acc_next = (acc_reg >> 1) + y_reg;
                    end else begin
                        acc_next = acc_reg >> 1;
                    end
                    y_next   = y_reg >> 2;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'(W / 2 - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ----- rtl/fixed_point_calculator_keypad_engine_core.sv -----
// Top level of the calculator keypad engine: key sequencer and state.
//
// Channel | Dir | Handshake              | Payload
// s_axis  | in  | s_tvalid / s_tready    | s_tdata: op[4:0], digit[8:5]
// m_axis  | out | m_tvalid / m_tready    | m_tdata: display_value[63:0]; m_tuser: memory[1], error[0]
//
// A simple key gives its result without the shared unit; one 64-step pass of the
// shared unit serves a fraction digit, percent or reciprocal, two passes (delete, square,
// pending multiply or divide) serve the rest. Root is one multiply and 32 root steps.
// Reset clears the calculator registers and the unit's busy and done flags; the latched key and digit are not reset.
// s_tready is low while a key is in work or its result waits; m_tvalid holds under stall.
module fixed_point_calculator_keypad_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[4:0], digit[8:5], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // display_value
    output logic [1:0]  m_tuser    // memory_flag, error_flag
);
    localparam int unsigned W = fpcalc_pkg::ValW;

    fpcalc_pkg::state_t state_reg, state_next;
    logic [4:0]   key_reg, key_next;
    logic [3:0]   dig_reg, dig_next;
    logic [W-1:0] entry_reg, entry_next;
    logic [W-1:0] oper_reg, oper_next;
    logic [W-1:0] mem_reg, mem_next;
    fpcalc_pkg::pend_t pend_reg, pend_next;
    logic         newent_reg, newent_next;
    logic         frac_reg, frac_next;
    logic [16:0]  fdiv_reg, fdiv_next;
    logic         mflag_reg, mflag_next;
    logic         err_reg, err_next;

    fpcalc_pkg::au_req_t req;
    fpcalc_pkg::au_rsp_t rsp;

    fpcalc_arith u_arith (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    logic [W-1:0] dscaled;
    logic [3:0]   dclip;
    assign dclip   = (s_tdata[8:5] > 4'd9) ? 4'd9 : s_tdata[8:5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= fpcalc_pkg::ST_IDLE;
            entry_reg  <= '0;
            oper_reg   <= '0;
            mem_reg    <= '0;
            pend_reg   <= fpcalc_pkg::PEND_NONE;
            newent_reg <= 1'b1;
            frac_reg   <= 1'b0;
            fdiv_reg   <= fpcalc_pkg::FracTen;
            mflag_reg  <= 1'b0;
            err_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            entry_reg  <= entry_next;
            oper_reg   <= oper_next;
            mem_reg    <= mem_next;
            pend_reg   <= pend_next;
            newent_reg <= newent_next;
            frac_reg   <= frac_next;
            fdiv_reg   <= fdiv_next;
            mflag_reg  <= mflag_next;
            err_reg    <= err_next;
        end
        key_reg <= key_next;
        dig_reg <= dig_next;
    end

    always_comb begin
        state_next  = state_reg;
        key_next    = key_reg;
        dig_next    = dig_reg;
        entry_next  = entry_reg;
        oper_next   = oper_reg;
        mem_next    = mem_reg;
        pend_next   = pend_reg;
        newent_next = newent_reg;
        frac_next   = frac_reg;
        fdiv_next   = fdiv_reg;
        mflag_next  = mflag_reg;
        err_next    = err_reg;
        req.start   = 1'b0;
        req.op      = fpcalc_pkg::AU_MUL;
        req.a       = '0;
        req.b       = '0;
        dscaled     = W'(dig_reg) * fpcalc_pkg::Scale;
        s_tready    = (state_reg == fpcalc_pkg::ST_IDLE);
        m_tvalid    = (state_reg == fpcalc_pkg::ST_OUT);
        case (state_reg)
            fpcalc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    key_next   = s_tdata[4:0];
                    dig_next   = dclip;
                    state_next = fpcalc_pkg::ST_OP1;
                end
            end
            fpcalc_pkg::ST_OP1: begin
                // simple keys finish here; others launch the shared unit
                state_next = fpcalc_pkg::ST_OUT;
                case (key_reg)
                    fpcalc_pkg::KEY_DIGIT: begin
                        if (newent_reg) begin
                            entry_next  = dscaled;
                            newent_next = 1'b0;
                            frac_next   = 1'b0;
                            fdiv_next   = fpcalc_pkg::FracTen;
                        end else if (frac_reg) begin
                            if (fdiv_reg <= fpcalc_pkg::FracLimit) begin
                                req.start  = 1'b1;
                                req.op     = fpcalc_pkg::AU_DIV;
                                req.a      = dscaled;
                                req.b      = W'(fdiv_reg);
                                state_next = fpcalc_pkg::ST_WAIT2;
                            end
                        end else begin
                            entry_next = (entry_reg << 3) + (entry_reg << 1) + dscaled;
                        end
                    end
                    fpcalc_pkg::KEY_DZERO: begin
                        if (!newent_reg && !frac_reg)
                            entry_next = (entry_reg << 6) + (entry_reg << 5) + (entry_reg << 2);
                    end
                    fpcalc_pkg::KEY_POINT: begin
                        if (newent_reg) begin
                            entry_next  = '0;
                            newent_next = 1'b0;
                        end
                        frac_next = 1'b1;
                        fdiv_next = fpcalc_pkg::FracTen;
                    end
                    fpcalc_pkg::KEY_CLEAR: begin
                        entry_next = '0; oper_next = '0; mem_next = '0;
                        pend_next = fpcalc_pkg::PEND_NONE; newent_next = 1'b1;
                        frac_next = 1'b0; fdiv_next = fpcalc_pkg::FracTen;
                        mflag_next = 1'b0; err_next = 1'b0;
                    end
                    fpcalc_pkg::KEY_DELETE: begin
                        if (!newent_reg) begin
                            req.start  = 1'b1;
                            req.op     = fpcalc_pkg::AU_DIV;
                            req.a      = entry_reg;
                            req.b      = fpcalc_pkg::DelDiv;
                            state_next = fpcalc_pkg::ST_WAIT1;
                        end
                    end
                    fpcalc_pkg::KEY_NEGATE: entry_next = -entry_reg;
                    fpcalc_pkg::KEY_ADD, fpcalc_pkg::KEY_SUB, fpcalc_pkg::KEY_MUL,
                    fpcalc_pkg::KEY_DIV, fpcalc_pkg::KEY_EQUALS: begin
                        if (err_reg) begin
                            entry_next = '0; oper_next = '0; mem_next = '0;
                            pend_next = fpcalc_pkg::PEND_NONE; newent_next = 1'b1;
                            frac_next = 1'b0; fdiv_next = fpcalc_pkg::FracTen;
                            mflag_next = 1'b0; err_next = 1'b0;
                        end else begin
                            case (pend_reg)
                                fpcalc_pkg::PEND_ADD: begin
                                    oper_next  = oper_reg + entry_reg;
                                    entry_next = oper_reg + entry_reg;
                                end
                                fpcalc_pkg::PEND_SUB: begin
                                    oper_next  = oper_reg - entry_reg;
                                    entry_next = oper_reg - entry_reg;
                                end
                                fpcalc_pkg::PEND_MUL: begin
                                    req.start  = 1'b1;
                                    req.a      = oper_reg;
                                    req.b      = entry_reg;
                                    state_next = fpcalc_pkg::ST_WAIT1;
                                end
                                fpcalc_pkg::PEND_DIV: begin
                                    if (entry_reg == '0) begin
                                        err_next   = 1'b1;
                                        entry_next = oper_reg;
                                    end else begin
                                        req.start  = 1'b1;
                                        req.a      = oper_reg;
                                        req.b      = fpcalc_pkg::Scale;
                                        state_next = fpcalc_pkg::ST_WAIT1;
                                    end
                                end
                                default: oper_next = entry_reg;
                            endcase
                            // multiply and divide keep the old operator until their result lands
                            if (pend_reg != fpcalc_pkg::PEND_MUL &&
                                pend_reg != fpcalc_pkg::PEND_DIV) begin
                                case (key_reg)
                                    fpcalc_pkg::KEY_ADD: pend_next = fpcalc_pkg::PEND_ADD;
                                    fpcalc_pkg::KEY_SUB: pend_next = fpcalc_pkg::PEND_SUB;
                                    fpcalc_pkg::KEY_MUL: pend_next = fpcalc_pkg::PEND_MUL;
                                    fpcalc_pkg::KEY_DIV: pend_next = fpcalc_pkg::PEND_DIV;
                                    default:             pend_next = fpcalc_pkg::PEND_NONE;
                                endcase
                            end
                            newent_next = 1'b1;
                            frac_next   = 1'b0;
                            fdiv_next   = fpcalc_pkg::FracTen;
                        end
                    end
                    fpcalc_pkg::KEY_PERCENT: begin
                        req.start  = 1'b1;
                        req.op     = fpcalc_pkg::AU_DIV;
                        req.a      = entry_reg;
                        req.b      = fpcalc_pkg::Hundred;
                        state_next = fpcalc_pkg::ST_WAIT2;
                    end
                    fpcalc_pkg::KEY_SQUARE, fpcalc_pkg::KEY_SQRT: begin
                        if (key_reg == fpcalc_pkg::KEY_SQRT && entry_reg[W-1]) begin
                            err_next = 1'b1;
                        end else begin
                            req.start  = 1'b1;
                            req.a      = entry_reg;
                            req.b      = (key_reg == fpcalc_pkg::KEY_SQRT) ?
                                         fpcalc_pkg::Scale : entry_reg;
                            state_next = fpcalc_pkg::ST_WAIT1;
                        end
                    end
                    fpcalc_pkg::KEY_RECIP: begin
                        if (entry_reg == '0) begin
                            err_next = 1'b1;
                        end else begin
                            req.start  = 1'b1;
                            req.op     = fpcalc_pkg::AU_DIV;
                            req.a      = fpcalc_pkg::ScaleSq;
                            req.b      = entry_reg;
                            state_next = fpcalc_pkg::ST_WAIT2;
                        end
                    end
                    fpcalc_pkg::KEY_MC: begin
                        mem_next   = '0;
                        mflag_next = 1'b0;
                    end
                    fpcalc_pkg::KEY_MR: begin
                        entry_next  = mem_reg;
                        newent_next = 1'b1;
                    end
                    fpcalc_pkg::KEY_MADD, fpcalc_pkg::KEY_MSUB: begin
                        mem_next    = (key_reg == fpcalc_pkg::KEY_MADD) ?
                                      mem_reg + entry_reg : mem_reg - entry_reg;
                        mflag_next  = 1'b1;
                        newent_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            fpcalc_pkg::ST_WAIT1: begin
                if (rsp.done) state_next = fpcalc_pkg::ST_OP2;
            end
            fpcalc_pkg::ST_OP2: begin
                // second pass of the shared unit
                state_next = fpcalc_pkg::ST_WAIT2;
                req.start  = 1'b1;
                case (key_reg)
                    fpcalc_pkg::KEY_DELETE: begin
                        req.op = fpcalc_pkg::AU_MUL;
                        req.a  = rsp.result;
                        req.b  = fpcalc_pkg::Scale;
                    end
                    fpcalc_pkg::KEY_SQRT: begin
                        req.op = fpcalc_pkg::AU_SQRT;
                        req.a  = rsp.result;
                    end
                    default: begin
                        req.op = fpcalc_pkg::AU_DIV;
                        if (key_reg != fpcalc_pkg::KEY_SQUARE &&
                            pend_reg == fpcalc_pkg::PEND_DIV) begin
                            req.a = rsp.result;
                            req.b = entry_reg;
                        end else begin
                            req.a = rsp.result;
                            req.b = fpcalc_pkg::Scale;
                        end
                    end
                endcase
            end
            fpcalc_pkg::ST_WAIT2: begin
                if (rsp.done) begin
                    state_next = fpcalc_pkg::ST_OUT;
                    case (key_reg)
                        fpcalc_pkg::KEY_DIGIT: begin
                            entry_next = entry_reg + rsp.result;
                            fdiv_next  = (fdiv_reg << 3) + (fdiv_reg << 1);
                        end
                        fpcalc_pkg::KEY_ADD, fpcalc_pkg::KEY_SUB, fpcalc_pkg::KEY_MUL,
                        fpcalc_pkg::KEY_DIV, fpcalc_pkg::KEY_EQUALS: begin
                            oper_next  = rsp.result;
                            entry_next = rsp.result;
                            case (key_reg)
                                fpcalc_pkg::KEY_ADD: pend_next = fpcalc_pkg::PEND_ADD;
                                fpcalc_pkg::KEY_SUB: pend_next = fpcalc_pkg::PEND_SUB;
                                fpcalc_pkg::KEY_MUL: pend_next = fpcalc_pkg::PEND_MUL;
                                fpcalc_pkg::KEY_DIV: pend_next = fpcalc_pkg::PEND_DIV;
                                default:             pend_next = fpcalc_pkg::PEND_NONE;
                            endcase
                        end
                        default: entry_next = rsp.result;
                    endcase
                end
            end
            fpcalc_pkg::ST_OUT: begin
                if (m_tready) state_next = fpcalc_pkg::ST_IDLE;
            end
            default: state_next = fpcalc_pkg::ST_IDLE;
        endcase
    end

    assign m_tdata = entry_reg;
    assign m_tuser = {mflag_reg, err_reg};

endmodule

// ----- rtl/fpcalc_checker.sv -----
// Port-level checker for the calculator keypad engine, bound to the top level.
module fpcalc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // one key in work at a time
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result dropped under stall");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[4:0] == fpcalc_pkg::KEY_CLEAR) |=> ##1
        (m_tvalid && m_tdata == 64'd0 && m_tuser == 2'b00)) else $error("clear wrong");
endmodule

bind fixed_point_calculator_keypad_engine_core fpcalc_checker u_fpcalc_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for the calculator keypad engine: keys in, display and flags out.
`timescale 1ns / 100ps

module tb_top;

    localparam int CycleLimit = 1500000;
    localparam int HoldOffLen = 2000;

    typedef struct {
        logic [4:0] op;
        logic [3:0] dg;
    } keypress_t;

    typedef struct {
        logic [63:0] val;
        logic        err;
        logic        mem;
    } display_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    keypress_t key_queue[$];
    display_t  display_queue[$];
    int        failures = 0;
    int        results_seen = 0;
    int        cycles = 0;

    // model of the calculator state
    logic [63:0] entry_val, operand_val, mem_store;
    fpcalc_pkg::pend_t pend_op;
    logic        new_entry, frac_on, mem_on, err_on;
    logic [16:0] frac_div;

    fixed_point_calculator_keypad_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void clear_calc();
        entry_val = '0; operand_val = '0; mem_store = '0;
        pend_op = fpcalc_pkg::PEND_NONE; new_entry = 1'b1; frac_on = 1'b0;
        frac_div = fpcalc_pkg::FracTen; mem_on = 1'b0; err_on = 1'b0;
    endfunction

    // truncating signed divide, most negative over minus one wraps
    function automatic logic [63:0] trunc_div(logic [63:0] a, logic [63:0] b);
        if ($signed(b) == -64'sd1)
            return -a;
        return $signed(a) / $signed(b);
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] rem, root, bitv;
        if ($signed(v) <= 0)
            return '0;
        rem = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic void operator_key(fpcalc_pkg::pend_t nxt);
        if (err_on) begin
            clear_calc();
            return;
        end
        if (pend_op != fpcalc_pkg::PEND_NONE) begin
            case (pend_op)
                fpcalc_pkg::PEND_ADD: operand_val = operand_val + entry_val;
                fpcalc_pkg::PEND_SUB: operand_val = operand_val - entry_val;
                fpcalc_pkg::PEND_MUL:
                    operand_val = trunc_div(operand_val * entry_val, fpcalc_pkg::Scale);
                fpcalc_pkg::PEND_DIV: begin
                    if (entry_val == 0)
                        err_on = 1'b1;
                    else
                        operand_val = trunc_div(operand_val * fpcalc_pkg::Scale, entry_val);
                end
                default: ;
            endcase
            entry_val = operand_val;
        end else begin
            operand_val = entry_val;
        end
        if (!err_on)
            pend_op = nxt;
        new_entry = 1'b1;
        frac_on = 1'b0;
        frac_div = fpcalc_pkg::FracTen;
    endfunction

    function automatic void press_key(keypress_t k);
        logic [63:0] d;
        display_t    res;
        d = (k.dg > 4'd9) ? 64'd9 : {60'd0, k.dg};
        case (fpcalc_pkg::key_t'(k.op))
            fpcalc_pkg::KEY_DIGIT: begin
                if (new_entry) begin
                    entry_val = d * fpcalc_pkg::Scale;
                    new_entry = 1'b0;
                    frac_on = 1'b0;
                    frac_div = fpcalc_pkg::FracTen;
                end else if (frac_on) begin
                    if (frac_div <= fpcalc_pkg::FracLimit) begin
                        entry_val = entry_val + (d * fpcalc_pkg::Scale) / {47'd0, frac_div};
                        frac_div = frac_div * 17'd10;
                    end
                end else begin
                    entry_val = entry_val * 64'd10 + d * fpcalc_pkg::Scale;
                end
            end
            fpcalc_pkg::KEY_DZERO:
                if (!new_entry && !frac_on) entry_val = entry_val * fpcalc_pkg::Hundred;
            fpcalc_pkg::KEY_POINT: begin
                if (new_entry) begin
                    entry_val = '0;
                    new_entry = 1'b0;
                end
                frac_on = 1'b1;
                frac_div = fpcalc_pkg::FracTen;
            end
            fpcalc_pkg::KEY_CLEAR:   clear_calc();
            fpcalc_pkg::KEY_DELETE:
                if (!new_entry)
                    entry_val = trunc_div(entry_val, fpcalc_pkg::DelDiv) * fpcalc_pkg::Scale;
            fpcalc_pkg::KEY_NEGATE:  entry_val = -entry_val;
            fpcalc_pkg::KEY_ADD:     operator_key(fpcalc_pkg::PEND_ADD);
            fpcalc_pkg::KEY_SUB:     operator_key(fpcalc_pkg::PEND_SUB);
            fpcalc_pkg::KEY_MUL:     operator_key(fpcalc_pkg::PEND_MUL);
            fpcalc_pkg::KEY_DIV:     operator_key(fpcalc_pkg::PEND_DIV);
            fpcalc_pkg::KEY_EQUALS:  operator_key(fpcalc_pkg::PEND_NONE);
            fpcalc_pkg::KEY_PERCENT: entry_val = trunc_div(entry_val, fpcalc_pkg::Hundred);
            fpcalc_pkg::KEY_SQUARE:
                entry_val = trunc_div(entry_val * entry_val, fpcalc_pkg::Scale);
            fpcalc_pkg::KEY_SQRT: begin
                if ($signed(entry_val) < 0)
                    err_on = 1'b1;
                else
                    entry_val = floor_root(entry_val * fpcalc_pkg::Scale);
            end
            fpcalc_pkg::KEY_RECIP: begin
                if (entry_val == 0)
                    err_on = 1'b1;
                else
                    entry_val = trunc_div(fpcalc_pkg::ScaleSq, entry_val);
            end
            fpcalc_pkg::KEY_MC: begin
                mem_store = '0;
                mem_on = 1'b0;
            end
            fpcalc_pkg::KEY_MR: begin
                entry_val = mem_store;
                new_entry = 1'b1;
            end
            fpcalc_pkg::KEY_MADD: begin
                mem_store = mem_store + entry_val;
                mem_on = 1'b1;
                new_entry = 1'b1;
            end
            fpcalc_pkg::KEY_MSUB: begin
                mem_store = mem_store - entry_val;
                mem_on = 1'b1;
                new_entry = 1'b1;
            end
            default: ;
        endcase
        res.val = entry_val;
        res.err = err_on;
        res.mem = mem_on;
        display_queue.push_back(res);
    endfunction

    function automatic void queue_key(fpcalc_pkg::key_t op, int dg = 0);
        keypress_t k;
        k.op = op;
        k.dg = dg[3:0];
        key_queue.push_back(k);
    endfunction

    // sender: bursts of transactions separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                press_key(key_queue.pop_front());
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || key_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, key_queue[0].dg, key_queue[0].op};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver: stall pattern changes every so often, one long hold-off
    int  mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= 400) begin
            hold_done = 1;
            hold_left = HoldOffLen;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        display_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (display_queue.size() == 0) begin
                $display("%0t: unexpected result value=%0d flags=%b", $time,
                         $signed(m_tdata), m_tuser);
                failures++;
            end else begin
                want = display_queue.pop_front();
                if (m_tdata !== want.val) begin
                    $display("%0t: display_value expected %0d actual %0d", $time,
                             $signed(want.val), $signed(m_tdata));
                    failures++;
                end
                if (m_tuser[0] !== want.err) begin
                    $display("%0t: error_flag expected %b actual %b", $time,
                             want.err, m_tuser[0]);
                    failures++;
                end
                if (m_tuser[1] !== want.mem) begin
                    $display("%0t: memory_flag expected %b actual %b", $time,
                             want.mem, m_tuser[1]);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("fixed_point_calculator_keypad_engine_core regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (cycles == 5)
            aresetn <= 1'b1;
    end

    initial begin
        int n, roll;
        clear_calc();

        // directed: entry limits, every key, the odd corners
        queue_key(fpcalc_pkg::KEY_DIGIT, 9);
        queue_key(fpcalc_pkg::KEY_DIGIT, 15);          // above nine counts as nine
        queue_key(fpcalc_pkg::KEY_DZERO);
        queue_key(fpcalc_pkg::KEY_POINT);
        for (int i = 1; i <= 5; i++)
            queue_key(fpcalc_pkg::KEY_DIGIT, i);       // fifth fraction digit is dropped
        queue_key(fpcalc_pkg::KEY_NEGATE);
        queue_key(fpcalc_pkg::KEY_MUL);
        queue_key(fpcalc_pkg::KEY_DIGIT, 3);
        queue_key(fpcalc_pkg::KEY_EQUALS);
        queue_key(fpcalc_pkg::KEY_DELETE);
        queue_key(fpcalc_pkg::KEY_PERCENT);
        queue_key(fpcalc_pkg::KEY_SQUARE);
        queue_key(fpcalc_pkg::KEY_MADD);
        queue_key(fpcalc_pkg::KEY_SQRT);               // root of the squared value
        queue_key(fpcalc_pkg::KEY_RECIP);
        queue_key(fpcalc_pkg::KEY_MR);
        queue_key(fpcalc_pkg::KEY_MSUB);
        queue_key(fpcalc_pkg::KEY_MC);
        queue_key(fpcalc_pkg::KEY_ADD);                // operator with no pending operation
        queue_key(fpcalc_pkg::KEY_RECIP);              // reciprocal of the recalled value
        queue_key(fpcalc_pkg::KEY_CLEAR);
        queue_key(fpcalc_pkg::KEY_DIGIT, 7);
        queue_key(fpcalc_pkg::KEY_DIV);
        queue_key(fpcalc_pkg::KEY_DIGIT, 0);
        queue_key(fpcalc_pkg::KEY_EQUALS);             // divide by zero
        queue_key(fpcalc_pkg::key_t'(5'd31), 15);      // unused code
        queue_key(fpcalc_pkg::KEY_SUB);
        queue_key(fpcalc_pkg::KEY_CLEAR);

        // random: mostly numbers and operators, some noise
        while (key_queue.size() < 1850) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                n = $urandom_range(0, 8) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    queue_key($urandom_range(0, 9) == 0 ? fpcalc_pkg::KEY_DZERO :
                              fpcalc_pkg::KEY_DIGIT, $urandom_range(0, 15));
                if ($urandom_range(0, 2) == 0) begin
                    queue_key(fpcalc_pkg::KEY_POINT);
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++)
                        queue_key(fpcalc_pkg::KEY_DIGIT, $urandom_range(0, 9));
                end
                if ($urandom_range(0, 4) == 0)
                    queue_key(fpcalc_pkg::key_t'($urandom_range(fpcalc_pkg::KEY_DELETE,
                                                                fpcalc_pkg::KEY_NEGATE)));
                if ($urandom_range(0, 3) == 0)
                    queue_key(fpcalc_pkg::key_t'($urandom_range(fpcalc_pkg::KEY_PERCENT,
                                                                fpcalc_pkg::KEY_MSUB)));
                queue_key(fpcalc_pkg::key_t'($urandom_range(fpcalc_pkg::KEY_ADD,
                                                            fpcalc_pkg::KEY_EQUALS)));
            end else if (roll < 95) begin
                queue_key(fpcalc_pkg::key_t'($urandom_range(0, 18)), $urandom_range(0, 15));
            end else begin
                queue_key(fpcalc_pkg::key_t'($urandom_range(0, 31)), $urandom_range(0, 15));
            end
        end

        while (key_queue.size() != 0 || display_queue.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (failures == 0)
            $display("fixed_point_calculator_keypad_engine_core regression: pass");
        else
            $display("fixed_point_calculator_keypad_engine_core regression: fail");
        $finish;
    end

endmodule
